/* rtl/assert_macros.svh */
// Assertion macros for the RTL; included by rabin_fingerprint_stream_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/rfs_pkg.sv */
// Types and constants for the Rabin fingerprint stream unit.
`default_nettype none

package rfs_pkg;

  localparam int WORD_W = 32;
  localparam int FP_W   = 64;

  localparam logic [FP_W-1:0] POLY_RESET = 64'd9271613880639673933;

  // Table of x^(64+i) mod P for i = 0..31 is built from the chain
  // f^k(x^62), entries k = SWEEP_FIRST..SWEEP_LAST.
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] SWEEP_FIRST = 6'd2;
  localparam logic [STEP_W-1:0] SWEEP_LAST  = 6'd33;
  localparam int SEED_BIT = 62;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_LATER  = 2'd2
  } pos_t;

endpackage

`default_nettype wire

/* rtl/rabin_fingerprint_stream_unit.sv */
// Rabin fingerprint stream unit: 64-bit polynomial fingerprint over 32-bit words.
`default_nettype none

// Takes one 32-bit word per cycle on the s_ side while s_tready is high; the
// word with s_tlast set closes the message and its 64-bit fingerprint is
// registered into m_tdata, or into the skid entry while the output is stalled.
// The fold of the old high half is an XOR of up to 32 table entries
// (x^(64+i) mod P). After reset and after every polynomial write the table is
// rebuilt one entry per cycle; s_tready stays low while that runs. A two-deep
// result buffer keeps input flowing while a fingerprint waits for m_tready.
module rabin_fingerprint_stream_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [rfs_pkg::FP_W-1:0]  cfg_wdata,   // polynomial
  input  wire logic                      s_tvalid,
  output      logic                      s_tready,
  input  wire logic [rfs_pkg::WORD_W-1:0] s_tdata,    // [31:0] word
  input  wire logic                      s_tlast,
  output      logic                      m_tvalid,
  input  wire logic                      m_tready,
  output      logic [rfs_pkg::FP_W-1:0]  m_tdata      // [63:0] fingerprint
);

  import rfs_pkg::*;

  `include "assert_macros.svh"

  localparam int TBL_N = WORD_W;
  localparam int IDX_W = $clog2(TBL_N);

  logic [FP_W-1:0]   polynomial;
  logic [FP_W-1:0]   chain;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [FP_W-1:0]   table_q [TBL_N];

  logic [WORD_W-1:0] high_half, low_half;
  logic [WORD_W-1:0] high_half_next, low_half_next;
  pos_t              pos, pos_next;

  logic [FP_W-1:0]   skid;
  logic              skid_valid;

  logic              accept, slot_free;
  logic [FP_W-1:0]   fold, mixed, fp;
  logic [FP_W-1:0]   chain_shift, chain_next;
  logic [STEP_W-1:0] step_off;

  // One shift-and-reduce step of the chain.
  always_comb begin
    chain_shift = {chain[FP_W-2:0], 1'b0};
    chain_next  = chain_shift[FP_W-1] ? (chain_shift ^ polynomial) : chain_shift;
    step_off    = step - SWEEP_FIRST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial <= POLY_RESET;
      busy       <= 1'b1;
      step       <= '0;
      chain      <= FP_W'(1) << SEED_BIT;
    end else if (cfg_we) begin
      polynomial <= cfg_wdata;
      busy       <= 1'b1;
      step       <= '0;
      chain      <= FP_W'(1) << SEED_BIT;
    end else if (busy) begin
      chain <= chain_next;
      step  <= step + 1'b1;
      if (step == SWEEP_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && step >= SWEEP_FIRST) begin
      table_q[step_off[IDX_W-1:0]] <= chain;
    end
  end

  // Fold of the old high half.
  always_comb begin
    fold = '0;
    for (int i = 0; i < TBL_N; i++) begin
      if (high_half[i]) begin
        fold = fold ^ table_q[i];
      end
    end
    mixed = {low_half, s_tdata} ^ fold;
  end

  assign s_tready = !busy && !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // Next word position.
  always_comb begin
    if (!accept) begin
      pos_next = pos;
    end else if (s_tlast) begin
      pos_next = POS_FIRST;
    end else begin
      case (pos)
        POS_FIRST:  pos_next = POS_SECOND;
        POS_SECOND: pos_next = POS_LATER;
        default:    pos_next = POS_LATER;
      endcase
    end
  end

  // Datapath outputs for the accepted word.
  always_comb begin
    case (pos)
      POS_FIRST: begin
        high_half_next = s_tdata;
        low_half_next  = '0;
      end
      POS_SECOND: begin
        high_half_next = high_half;
        low_half_next  = s_tdata;
      end
      default: begin
        high_half_next = mixed[FP_W-1:WORD_W];
        low_half_next  = mixed[WORD_W-1:0];
      end
    endcase
    fp = {high_half_next, low_half_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_FIRST;
      high_half <= '0;
      low_half  <= '0;
    end else begin
      pos <= pos_next;
      if (accept) begin
        high_half <= s_tlast ? '0 : high_half_next;
        low_half  <= s_tlast ? '0 : low_half_next;
      end
    end
  end

  // Result register plus skid entry.
  assign slot_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept && s_tlast;
      end
    end else if (accept && s_tlast) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      m_tdata <= skid_valid ? skid : fp;
    end else if (accept && s_tlast) begin
      skid <= fp;
    end
  end

  `ASSERT_CLK(a_skid_behind_out, skid_valid |-> m_tvalid, "skid holds data while output empty")
  `ASSERT_CLK(a_cfg_stalls_input, cfg_we |=> !s_tready, "input ready right after polynomial write")
  `ASSERT_CLK(a_full_goes_to_skid, accept && s_tlast && m_tvalid && !m_tready |=> skid_valid, "result lost while output stalled")
  `ASSERT_CLK(a_sweep_ends, busy && step == SWEEP_LAST && !cfg_we |=> !busy, "table rebuild overran")

endmodule

`default_nettype wire
